### src/es2dt_pkg.sv
package es2dt_pkg;

  // Field widths
  localparam int unsigned SecsW  = 32;
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonW   = 4;
  localparam int unsigned DomW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;

  // Serial divider sizing
  localparam int unsigned DivRemW = 17;                    // holds 0 .. 86399
  localparam int unsigned DivCntW = $clog2(SecsW + 1);
  localparam int unsigned DaysW   = 16;                    // up to 49710 days

  localparam logic [DivRemW-1:0] SecsPerDay  = DivRemW'(86400);
  localparam logic [DivRemW-1:0] SecsPerHour = DivRemW'(3600);
  localparam logic [DivRemW-1:0] SecsPerMin  = DivRemW'(60);

  // Quotient bits needed per pass
  localparam logic [DivCntW-1:0] DayBits  = DivCntW'(32);
  localparam logic [DivCntW-1:0] HourBits = DivCntW'(17);
  localparam logic [DivCntW-1:0] MinBits  = DivCntW'(12);

  localparam logic [YearW-1:0] FirstYear = YearW'(1970);

  // Position of the first year within the leap cycles
  localparam logic [1:0] Mod4Init   = 2'd2;
  localparam logic [6:0] Mod100Init = 7'd70;
  localparam logic [8:0] Mod400Init = 9'd370;

  localparam logic [MonW-1:0] MonJan = MonW'(1);
  localparam logic [MonW-1:0] MonFeb = MonW'(2);
  localparam logic [MonW-1:0] MonApr = MonW'(4);
  localparam logic [MonW-1:0] MonJun = MonW'(6);
  localparam logic [MonW-1:0] MonSep = MonW'(9);
  localparam logic [MonW-1:0] MonNov = MonW'(11);

  typedef struct packed {
    logic                 start;
    logic [SecsW-1:0]     dividend;  // left aligned
    logic [DivRemW-1:0]   divisor;
    logic [DivCntW-1:0]   nbits;
  } div_cmd_t;

  typedef struct packed {
    logic                 done;
    logic [SecsW-1:0]     quo;       // low nbits valid
    logic [DivRemW-1:0]   rem;
  } div_rsp_t;

  function automatic logic [DomW-1:0] month_days(logic [MonW-1:0] mon, logic leap);
    logic [DomW-1:0] len;
    case (mon) inside
      MonFeb:                         len = leap ? DomW'(29) : DomW'(28);
      MonApr, MonJun, MonSep, MonNov: len = DomW'(30);
      default:                        len = DomW'(31);
    endcase
    return len;
  endfunction

endpackage

### src/es2dt_sdiv.sv
// Restoring divider, one quotient bit per cycle.
module es2dt_sdiv
  import es2dt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_cmd_t cmd_i,
  output div_rsp_t rsp_o
);

  logic [SecsW-1:0]   quo_q;
  logic [DivRemW-1:0] rem_q, rem_d, div_q;
  logic [DivCntW-1:0] cnt_q;
  logic               run_q, done_q;
  logic [DivRemW:0]   trial, diff;
  logic               ge;

  assign trial = {rem_q, quo_q[SecsW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};
  assign rem_d = ge ? diff[DivRemW-1:0] : trial[DivRemW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        run_q <= 1'b1;
        cnt_q <= cmd_i.nbits;
      end else if (run_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      quo_q <= cmd_i.dividend;
      rem_q <= '0;
      div_q <= cmd_i.divisor;
    end else if (run_q) begin
      quo_q <= {quo_q[SecsW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

### src/es2dt_cal_walk.sv
// Year then month walk over a zero-based day count.
module es2dt_cal_walk
  import es2dt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DaysW-1:0] days_i,
  output logic             done_o,
  output logic [YearW-1:0] year_o,
  output logic [MonW-1:0]  month_o,
  output logic [DomW-1:0]  dom_o
);

  typedef enum logic [2:0] {
    W_IDLE  = 3'b001,
    W_YEAR  = 3'b010,
    W_MONTH = 3'b100
  } walk_state_e;

  walk_state_e      state_q, state_d;
  logic [DaysW-1:0] days_q;
  logic [YearW-1:0] year_q;
  logic [MonW-1:0]  mon_q;
  logic [1:0]       m4_q;
  logic [6:0]       m100_q;
  logic [8:0]       m400_q;
  logic             done_q;
  logic             leap;
  logic [8:0]       ylen;
  logic [DomW-1:0]  mlen;
  logic             year_fits, mon_fits;

  assign leap      = (m4_q == 2'd0) && ((m100_q != 7'd0) || (m400_q == 9'd0));
  assign ylen      = leap ? 9'd366 : 9'd365;
  assign mlen      = month_days(mon_q, leap);
  assign year_fits = days_q < DaysW'(ylen);
  assign mon_fits  = days_q < DaysW'(mlen);

  always_comb begin
    state_d = state_q;
    case (state_q)
      W_IDLE:  if (start_i) state_d = W_YEAR;
      W_YEAR:  if (year_fits) state_d = W_MONTH;
      W_MONTH: if (mon_fits) state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == W_MONTH) && mon_fits;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      W_IDLE: begin
        if (start_i) begin
          days_q <= days_i;
          year_q <= FirstYear;
          mon_q  <= MonJan;
          m4_q   <= Mod4Init;
          m100_q <= Mod100Init;
          m400_q <= Mod400Init;
        end
      end
      W_YEAR: begin
        if (!year_fits) begin
          days_q <= days_q - DaysW'(ylen);
          year_q <= year_q + YearW'(1);
          m4_q   <= m4_q + 2'd1;
          m100_q <= (m100_q == 7'd99)  ? 7'd0 : m100_q + 7'd1;
          m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
        end
      end
      W_MONTH: begin
        if (!mon_fits) begin
          days_q <= days_q - DaysW'(mlen);
          mon_q  <= mon_q + MonW'(1);
        end
      end
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign year_o  = year_q;
  assign month_o = mon_q;
  assign dom_o   = days_q[DomW-1:0] + DomW'(1);

endmodule

### src/epoch_seconds_to_datetime.sv
// Unix seconds to Gregorian date and time of day.
//
// Command channel: drive epoch_seconds_i and raise start_i; the beat is taken
// at a rising edge where start_i is high and busy_o is low. busy_o stays high
// while the item is worked on.
// Result channel: valid_o is high for exactly one cycle, with year_o, month_o,
// day_of_month_o, hour_o, minute_o and second_o valid in that cycle only. The
// receiver cannot stall; a new command may be taken in the valid_o cycle.
//
// An accepted item runs three passes of the shared bit-serial divider (by
//   86400, 3600, 60), then a year walk from 1970 (up to 136 years) and a
//   month walk (up to 11 months), one year or one month at a time.
// One item is in flight at a time: a new command is not taken until the
// previous item reaches valid_o.
//
// Reset is asynchronous and returns both controllers to idle; no result is
// pending after reset and the data registers are simply overwritten later.
module epoch_seconds_to_datetime
  import es2dt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [SecsW-1:0] epoch_seconds_i,
  output logic             valid_o,
  output logic [YearW-1:0] year_o,
  output logic [MonW-1:0]  month_o,
  output logic [DomW-1:0]  day_of_month_o,
  output logic [HourW-1:0] hour_o,
  output logic [MinW-1:0]  minute_o,
  output logic [SecW-1:0]  second_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DAY  = 6'b000010,   // seconds / 86400
    S_HOUR = 6'b000100,   // remainder / 3600
    S_MIN  = 6'b001000,   // remainder / 60
    S_CAL  = 6'b010000,   // year and month walk
    S_DONE = 6'b100000    // result strobe
  } top_state_e;

  top_state_e       state_q, state_d;
  div_cmd_t         div_cmd;
  div_rsp_t         div_rsp;
  logic [DaysW-1:0] days_q;
  logic [HourW-1:0] hour_q;
  logic [MinW-1:0]  min_q;
  logic [SecW-1:0]  sec_q;
  logic             cal_start, cal_done;
  logic             accept;

  assign accept = start_i && ((state_q == S_IDLE) || (state_q == S_DONE));

  // Divider command: the next pass starts in the cycle the previous one ends.
  always_comb begin
    div_cmd = '0;
    case (state_q)
      S_IDLE, S_DONE: begin
        div_cmd.start    = start_i;
        div_cmd.dividend = epoch_seconds_i;
        div_cmd.divisor  = SecsPerDay;
        div_cmd.nbits    = DayBits;
      end
      S_DAY: begin
        div_cmd.start    = div_rsp.done;
        div_cmd.dividend = {div_rsp.rem, (SecsW - DivRemW)'(0)};
        div_cmd.divisor  = SecsPerHour;
        div_cmd.nbits    = HourBits;
      end
      S_HOUR: begin
        div_cmd.start    = div_rsp.done;
        div_cmd.dividend = {div_rsp.rem[11:0], (SecsW - 12)'(0)};
        div_cmd.divisor  = SecsPerMin;
        div_cmd.nbits    = MinBits;
      end
      default: div_cmd = '0;
    endcase
  end

  assign cal_start = (state_q == S_MIN) && div_rsp.done;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_DAY;
      S_DAY:   if (div_rsp.done) state_d = S_HOUR;
      S_HOUR:  if (div_rsp.done) state_d = S_MIN;
      S_MIN:   if (div_rsp.done) state_d = S_CAL;
      S_CAL:   if (cal_done) state_d = S_DONE;
      S_DONE:  state_d = accept ? S_DAY : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DAY) && div_rsp.done) begin
      days_q <= div_rsp.quo[DaysW-1:0];
    end
    if ((state_q == S_HOUR) && div_rsp.done) begin
      hour_q <= div_rsp.quo[HourW-1:0];
    end
    if ((state_q == S_MIN) && div_rsp.done) begin
      min_q <= div_rsp.quo[MinW-1:0];
      sec_q <= div_rsp.rem[SecW-1:0];
    end
  end

  es2dt_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .rsp_o  (div_rsp)
  );

  es2dt_cal_walk u_cal_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cal_start),
    .days_i  (days_q),
    .done_o  (cal_done),
    .year_o  (year_o),
    .month_o (month_o),
    .dom_o   (day_of_month_o)
  );

  assign busy_o   = !((state_q == S_IDLE) || (state_q == S_DONE));
  assign valid_o  = (state_q == S_DONE);
  assign hour_o   = hour_q;
  assign minute_o = min_q;
  assign second_o = sec_q;

endmodule

### src/es2dt_checker.sv
module es2dt_checker
  import es2dt_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             valid_o,
  input logic [YearW-1:0] year_o,
  input logic [MonW-1:0]  month_o,
  input logic [DomW-1:0]  day_of_month_o,
  input logic [HourW-1:0] hour_o,
  input logic [MinW-1:0]  minute_o,
  input logic [SecW-1:0]  second_o
);

  // A taken command keeps the block busy through the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy_o low right after a taken command");

  // Result strobe lasts one cycle.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("valid_o held for more than one cycle");

  // A result only follows a busy period.
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> $past(busy_o))
    else $error("valid_o without a preceding busy period");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (year_o >= YearW'(1970)) && (year_o <= YearW'(2106)) &&
                (month_o >= MonW'(1)) && (month_o <= MonW'(12)) &&
                (day_of_month_o >= DomW'(1)))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hour_o <= HourW'(23)) && (minute_o <= MinW'(59)) &&
                (second_o <= SecW'(59)))
    else $error("time field out of range");

endmodule

bind epoch_seconds_to_datetime es2dt_checker u_es2dt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .valid_o        (valid_o),
  .year_o         (year_o),
  .month_o        (month_o),
  .day_of_month_o (day_of_month_o),
  .hour_o         (hour_o),
  .minute_o       (minute_o),
  .second_o       (second_o)
);
